// ===== src/lcdseq_pkg.sv =====
package lcdseq_pkg;

    // Request opcodes
    localparam logic [2:0] OP_CMD     = 3'd0;
    localparam logic [2:0] OP_DATA    = 3'd1;
    localparam logic [2:0] OP_CURSOR  = 3'd2;
    localparam logic [2:0] OP_DISPLAY = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;
    localparam logic [2:0] OP_INIT    = 3'd5;

    // Waits after enable falls, in milliseconds
    localparam logic [5:0] WAIT_HOLD = 6'd1;
    localparam logic [5:0] WAIT_INIT = 6'd11;
    localparam logic [5:0] WAIT_LONG = 6'd51;

    // Fixed command bytes
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_DISPLAY  = 8'h08;
    localparam logic [7:0] CMD_DDRAM    = 8'h80;

    // Sequencer step counter and last step of each run
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] LAST_BYTE_8  = 4'd0;
    localparam logic [STEP_W-1:0] LAST_BYTE_4  = 4'd1;
    localparam logic [STEP_W-1:0] LAST_INIT_8  = 4'd5;
    localparam logic [STEP_W-1:0] LAST_INIT_4  = 4'd11;

    // Queue depths
    localparam int JOB_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] byte_value;
        logic [6:0] column;
        logic [1:0] row;
        logic       display_on;
        logic       cursor_on;
        logic       blink_on;
    } t_req;

    typedef struct packed {
        logic       register_select;
        logic [7:0] bus_value;
        logic [5:0] wait_after_ms;
        logic       last_strobe;
    } t_strobe;

    // Classified request handed from front to back
    typedef struct packed {
        logic       is_init;
        logic       nib;
        logic       rs;
        logic [7:0] byte_val;
        logic [5:0] wait_last;
    } t_job;

    // DDRAM row start addresses
    function automatic logic [6:0] row_offset(input logic [1:0] row);
        logic [6:0] off;
        case (row)
            2'd0:    off = 7'h00;
            2'd1:    off = 7'h40;
            2'd2:    off = 7'h14;
            default: off = 7'h54;
        endcase
        return off;
    endfunction

    // Init strobe table; nibble bus runs twelve steps, byte bus six
    function automatic t_strobe init_strobe(input logic nib, input logic [STEP_W-1:0] step);
        t_strobe s;
        s.register_select = 1'b0;
        s.last_strobe     = 1'b0;
        s.bus_value       = 8'h30;
        s.wait_after_ms   = WAIT_INIT;
        if (nib) begin
            case (step)
                4'd0, 4'd1, 4'd2: s.bus_value = 8'h30;
                4'd3:  s.bus_value = 8'h20;
                4'd4:  begin s.bus_value = 8'h20; s.wait_after_ms = WAIT_HOLD; end
                4'd5:  s.bus_value = 8'h80;
                4'd6:  begin s.bus_value = 8'h00; s.wait_after_ms = WAIT_HOLD; end
                4'd7:  s.bus_value = 8'hF0;
                4'd8:  begin s.bus_value = 8'h00; s.wait_after_ms = WAIT_HOLD; end
                4'd9:  begin s.bus_value = 8'h60; s.wait_after_ms = WAIT_LONG; end
                4'd10: begin s.bus_value = 8'h00; s.wait_after_ms = WAIT_HOLD; end
                default: begin s.bus_value = 8'h10; s.wait_after_ms = WAIT_LONG; end
            endcase
        end else begin
            case (step)
                4'd0, 4'd1, 4'd2: s.bus_value = 8'h30;
                4'd3:  s.bus_value = 8'h0F;
                4'd4:  begin s.bus_value = 8'h06; s.wait_after_ms = WAIT_LONG; end
                default: begin s.bus_value = 8'h01; s.wait_after_ms = WAIT_LONG; end
            endcase
        end
        return s;
    endfunction

endpackage

// ===== src/lcdseq_fifo.sv =====
module lcdseq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== src/lcdseq_front.sv =====
module lcdseq_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_push,
    input  lcdseq_pkg::t_req    i_req,
    input  logic                i_job_full,
    output logic                o_full,
    output logic                o_job_push,
    output lcdseq_pkg::t_job    o_job
);

    logic       r_bus_is_4bit;
    logic       op_valid;
    logic [6:0] cursor_addr;

    // bus width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_is_4bit <= 1'b0;
        end else if (i_cfg_we) begin
            r_bus_is_4bit <= i_cfg_wdata;
        end
    end

    assign cursor_addr = lcdseq_pkg::row_offset(i_req.row) + i_req.column;

    // classify request into a job
    always_comb begin
        op_valid        = 1'b1;
        o_job.is_init   = 1'b0;
        o_job.nib       = r_bus_is_4bit;
        o_job.rs        = 1'b0;
        o_job.byte_val  = i_req.byte_value;
        o_job.wait_last = lcdseq_pkg::WAIT_HOLD;
        unique case (i_req.opcode)
            lcdseq_pkg::OP_CMD: begin
            end
            lcdseq_pkg::OP_DATA: begin
                o_job.rs = 1'b1;
            end
            lcdseq_pkg::OP_CURSOR: begin
                o_job.byte_val = lcdseq_pkg::CMD_DDRAM | {1'b0, cursor_addr};
            end
            lcdseq_pkg::OP_DISPLAY: begin
                o_job.byte_val = lcdseq_pkg::CMD_DISPLAY
                               | {5'd0, i_req.display_on, i_req.cursor_on, i_req.blink_on};
            end
            lcdseq_pkg::OP_CLEAR: begin
                o_job.byte_val  = lcdseq_pkg::CMD_CLEAR;
                o_job.wait_last = lcdseq_pkg::WAIT_LONG;
            end
            lcdseq_pkg::OP_INIT: begin
                o_job.is_init = 1'b1;
            end
            default: begin
                // unused opcodes are taken and dropped
                op_valid = 1'b0;
            end
        endcase
    end

    assign o_full     = i_job_full;
    assign o_job_push = i_push && !i_job_full && op_valid;

endmodule

// ===== src/lcdseq_back.sv =====
module lcdseq_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  lcdseq_pkg::t_job    i_job,
    output logic                o_job_pop,
    input  logic                i_out_full,
    output logic                o_str_push,
    output lcdseq_pkg::t_strobe o_strobe
);

    logic [lcdseq_pkg::STEP_W-1:0] r_step, n_step;
    logic [lcdseq_pkg::STEP_W-1:0] last_idx;
    logic                          is_last;
    lcdseq_pkg::t_strobe           str;

    // last step index of the current job
    always_comb begin
        if (i_job.is_init) begin
            last_idx = i_job.nib ? lcdseq_pkg::LAST_INIT_4 : lcdseq_pkg::LAST_INIT_8;
        end else begin
            last_idx = i_job.nib ? lcdseq_pkg::LAST_BYTE_4 : lcdseq_pkg::LAST_BYTE_8;
        end
    end

    assign is_last = (r_step == last_idx);

    // strobe for the current step
    always_comb begin
        if (i_job.is_init) begin
            str = lcdseq_pkg::init_strobe(i_job.nib, r_step);
        end else begin
            str.register_select = i_job.rs;
            if (i_job.nib && !r_step[0]) begin
                str.bus_value     = {i_job.byte_val[7:4], 4'd0};
                str.wait_after_ms = lcdseq_pkg::WAIT_HOLD;
            end else if (i_job.nib) begin
                str.bus_value     = {i_job.byte_val[3:0], 4'd0};
                str.wait_after_ms = i_job.wait_last;
            end else begin
                str.bus_value     = i_job.byte_val;
                str.wait_after_ms = i_job.wait_last;
            end
            str.last_strobe = 1'b0;
        end
        o_strobe             = str;
        o_strobe.last_strobe = is_last;
    end

    assign o_str_push = i_job_valid && !i_out_full;
    assign o_job_pop  = o_str_push && is_last;

    // step counter
    always_comb begin
        n_step = r_step;
        if (o_job_pop) begin
            n_step = '0;
        end else if (o_str_push) begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

    // step never runs past the end of the run
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> (r_step <= last_idx))
        else $error("sequencer step beyond last strobe");

    // a strobe that is not last advances the step by one
    a_step_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_str_push && !is_last) |=> (r_step == $past(r_step) + 1'b1))
        else $error("sequencer step did not advance");

    // stalled output holds the step
    a_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job_valid && i_out_full) |=> $stable(r_step))
        else $error("sequencer step moved under stall");

    // a finished job restarts at step zero
    a_step_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_step == '0))
        else $error("sequencer did not restart after job");

endmodule

// ===== src/char_lcd_bus_sequencer_top.sv =====
// A pushed request is written into the job queue; the back end forms each strobe
// from the queue head and writes it into the result queue. Throughput: one strobe per
// cycle while a job is queued and the result queue has room; a request yields 1, 2, 6
// or 12 strobes (byte or init, 8- or 4-bit bus); a two-entry job queue and output queue
// decouple both sides. Reset clears the queues, the step counter and selects 8-bit bus.
module char_lcd_bus_sequencer_top #(
    parameter int JOB_DEPTH = lcdseq_pkg::JOB_DEPTH_DEF,
    parameter int OUT_DEPTH = lcdseq_pkg::OUT_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                push,
    output logic                full,
    input  lcdseq_pkg::t_req    i_req,
    output logic                empty,
    input  logic                pop,
    output lcdseq_pkg::t_strobe o_strobe
);

    logic                          job_push, job_full, job_empty, job_pop;
    lcdseq_pkg::t_job              job_in;
    logic [$bits(lcdseq_pkg::t_job)-1:0]    job_out;
    logic                          str_push, out_full;
    lcdseq_pkg::t_strobe           str_in;
    logic [$bits(lcdseq_pkg::t_strobe)-1:0] str_out;

    // request classification
    lcdseq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_req       (i_req),
        .i_job_full  (job_full),
        .o_full      (full),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    // job queue between front and back
    lcdseq_fifo #(
        .WIDTH ($bits(lcdseq_pkg::t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_push),
        .i_data  (job_in),
        .i_rd    (job_pop),
        .o_data  (job_out),
        .o_full  (job_full),
        .o_empty (job_empty)
    );

    // strobe sequencer
    lcdseq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!job_empty),
        .i_job       (lcdseq_pkg::t_job'(job_out)),
        .o_job_pop   (job_pop),
        .i_out_full  (out_full),
        .o_str_push  (str_push),
        .o_strobe    (str_in)
    );

    // result queue
    lcdseq_fifo #(
        .WIDTH ($bits(lcdseq_pkg::t_strobe)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (str_push),
        .i_data  (str_in),
        .i_rd    (pop),
        .o_data  (str_out),
        .o_full  (out_full),
        .o_empty (empty)
    );

    assign o_strobe = lcdseq_pkg::t_strobe'(str_out);

endmodule

// ===== test/tb_top.sv =====
module tb_top;

    // Opcodes the block has no strobes for
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    // Init sequence bytes
    localparam logic [7:0] INIT_WAKE    = 8'h30;
    localparam logic [7:0] INIT_NIBBLE  = 8'h20;
    localparam logic [7:0] FUNC_SET_4B  = 8'h28;
    localparam logic [7:0] DISP_ALL_ON  = 8'h0F;
    localparam logic [7:0] ENTRY_MODE   = 8'h06;

    localparam int DRAIN_CYCLES = 16;
    localparam int RAND_ITEMS   = 200;
    localparam int DIR_ROWS     = 23;
    localparam int REQ_W        = $bits(lcdseq_pkg::t_req);

    localparam lcdseq_pkg::t_strobe NO_STROBE = '0;

    typedef struct {
        logic                bus_nib;
        lcdseq_pkg::t_req    req;
        bit                  has_fixed;
        lcdseq_pkg::t_strobe fixed;
    } t_dir_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic                i_cfg_wdata = 1'b0;
    logic                push        = 1'b0;
    logic                pop         = 1'b0;
    lcdseq_pkg::t_req    i_req       = '0;
    logic                full;
    logic                empty;
    lcdseq_pkg::t_strobe o_strobe;

    // Predictor state and the strobes still owed by the block
    logic                bus_nib = 1'b0;
    lcdseq_pkg::t_strobe pending_strobes [$];
    lcdseq_pkg::t_strobe run_buf [0:11];
    int                  run_len;
    int                  errors = 0;
    bit                  send_eager = 1'b0;
    bit                  take_eager = 1'b0;

    t_dir_row dir_rows [0:DIR_ROWS-1];

    char_lcd_bus_sequencer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_req       (i_req),
        .empty       (empty),
        .pop         (pop),
        .o_strobe    (o_strobe)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // DDRAM start address of each display row
    function automatic logic [6:0] ddram_base(input logic [1:0] row);
        logic [6:0] base;
        case (row)
            2'd0:    base = 7'h00;
            2'd1:    base = 7'h40;
            2'd2:    base = 7'h14;
            default: base = 7'h54;
        endcase
        return base;
    endfunction

    function automatic void add_strobe(input logic rs, input logic [7:0] bv,
                                       input logic [5:0] wait_ms);
        run_buf[run_len] = '{rs, bv, wait_ms, 1'b0};
        run_len++;
    endfunction

    // A byte goes out whole, or high nibble then low nibble on bits 7..4
    function automatic void add_byte(input logic nib, input logic rs, input logic [7:0] b,
                                     input logic [5:0] wait_last);
        if (nib) begin
            add_strobe(rs, {b[7:4], 4'h0}, lcdseq_pkg::WAIT_HOLD);
            add_strobe(rs, {b[3:0], 4'h0}, wait_last);
        end else begin
            add_strobe(rs, b, wait_last);
        end
    endfunction

    // Work out the strobe run of one request and queue it
    function automatic void predict_strobes(input lcdseq_pkg::t_req r);
        logic [6:0] addr;
        addr = ddram_base(r.row) + r.column;
        run_len = 0;
        case (r.opcode)
            lcdseq_pkg::OP_CMD:
                add_byte(bus_nib, 1'b0, r.byte_value, lcdseq_pkg::WAIT_HOLD);
            lcdseq_pkg::OP_DATA:
                add_byte(bus_nib, 1'b1, r.byte_value, lcdseq_pkg::WAIT_HOLD);
            lcdseq_pkg::OP_CURSOR:
                add_byte(bus_nib, 1'b0, lcdseq_pkg::CMD_DDRAM | {1'b0, addr},
                         lcdseq_pkg::WAIT_HOLD);
            lcdseq_pkg::OP_DISPLAY:
                add_byte(bus_nib, 1'b0, lcdseq_pkg::CMD_DISPLAY
                         | {5'b0, r.display_on, r.cursor_on, r.blink_on},
                         lcdseq_pkg::WAIT_HOLD);
            lcdseq_pkg::OP_CLEAR:
                add_byte(bus_nib, 1'b0, lcdseq_pkg::CMD_CLEAR, lcdseq_pkg::WAIT_LONG);
            lcdseq_pkg::OP_INIT: begin
                add_strobe(1'b0, INIT_WAKE, lcdseq_pkg::WAIT_INIT);
                add_strobe(1'b0, INIT_WAKE, lcdseq_pkg::WAIT_INIT);
                add_strobe(1'b0, INIT_WAKE, lcdseq_pkg::WAIT_INIT);
                if (bus_nib) begin
                    add_strobe(1'b0, INIT_NIBBLE, lcdseq_pkg::WAIT_INIT);
                    add_byte(1'b1, 1'b0, FUNC_SET_4B, lcdseq_pkg::WAIT_INIT);
                end
                add_byte(bus_nib, 1'b0, DISP_ALL_ON, lcdseq_pkg::WAIT_INIT);
                add_byte(bus_nib, 1'b0, ENTRY_MODE, lcdseq_pkg::WAIT_LONG);
                add_byte(bus_nib, 1'b0, lcdseq_pkg::CMD_CLEAR, lcdseq_pkg::WAIT_LONG);
            end
            default: ;
        endcase
        if (run_len > 0) run_buf[run_len-1].last_strobe = 1'b1;
        for (int k = 0; k < run_len; k++) pending_strobes.push_back(run_buf[k]);
    endfunction

    function automatic t_dir_row dir_row(input logic nib, input logic [2:0] op,
                                         input logic [7:0] bv, input logic [6:0] col,
                                         input logic [1:0] rw, input logic [2:0] dcb,
                                         input bit has_fixed,
                                         input lcdseq_pkg::t_strobe fixed);
        t_dir_row d;
        d.bus_nib   = nib;
        d.req       = '{op, bv, col, rw, dcb[2], dcb[1], dcb[0]};
        d.has_fixed = has_fixed;
        d.fixed     = fixed;
        return d;
    endfunction

    // Park the input side, let every owed strobe drain, then let the block go quiet
    task automatic settle();
        push <= 1'b0;
        while (pending_strobes.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_bus(input logic nib);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= nib;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        bus_nib      = nib;
    endtask

    // One request transaction; push stays high on return so back-to-back items work
    task automatic send_req(input lcdseq_pkg::t_req r, input bit has_fixed,
                            input lcdseq_pkg::t_strobe fixed);
        int gap;
        gap = send_eager ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push  <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (full);
        if (has_fixed) pending_strobes.push_back(fixed);
        else predict_strobes(r);
        if ($urandom_range(0, 15) == 0) send_eager = !send_eager;
    endtask

    // Stimulus
    initial begin : stim
        lcdseq_pkg::t_req r;
        int               seg_left;
        dir_rows[0]  = dir_row(1'b0, lcdseq_pkg::OP_CMD,     8'h00, 7'h7F, 2'd3, 3'b111,
                               1'b1, '{1'b0, 8'h00, lcdseq_pkg::WAIT_HOLD, 1'b1});
        dir_rows[1]  = dir_row(1'b0, lcdseq_pkg::OP_CMD,     8'hFF, 7'h00, 2'd0, 3'b000,
                               1'b1, '{1'b0, 8'hFF, lcdseq_pkg::WAIT_HOLD, 1'b1});
        dir_rows[2]  = dir_row(1'b0, lcdseq_pkg::OP_DATA,    8'h00, 7'h55, 2'd2, 3'b010,
                               1'b1, '{1'b1, 8'h00, lcdseq_pkg::WAIT_HOLD, 1'b1});
        dir_rows[3]  = dir_row(1'b0, lcdseq_pkg::OP_DATA,    8'hFF, 7'h2A, 2'd1, 3'b101,
                               1'b1, '{1'b1, 8'hFF, lcdseq_pkg::WAIT_HOLD, 1'b1});
        dir_rows[4]  = dir_row(1'b0, lcdseq_pkg::OP_CURSOR,  8'hFF, 7'h00, 2'd0, 3'b111,
                               1'b1, '{1'b0, 8'h80, lcdseq_pkg::WAIT_HOLD, 1'b1});
        dir_rows[5]  = dir_row(1'b0, lcdseq_pkg::OP_CURSOR,  8'h00, 7'h7F, 2'd3, 3'b000,
                               1'b0, NO_STROBE);
        dir_rows[6]  = dir_row(1'b0, lcdseq_pkg::OP_DISPLAY, 8'h00, 7'h00, 2'd0, 3'b111,
                               1'b1, '{1'b0, 8'h0F, lcdseq_pkg::WAIT_HOLD, 1'b1});
        dir_rows[7]  = dir_row(1'b0, lcdseq_pkg::OP_DISPLAY, 8'hFF, 7'h7F, 2'd3, 3'b000,
                               1'b1, '{1'b0, 8'h08, lcdseq_pkg::WAIT_HOLD, 1'b1});
        dir_rows[8]  = dir_row(1'b0, lcdseq_pkg::OP_CLEAR,   8'hFF, 7'h7F, 2'd3, 3'b111,
                               1'b1, '{1'b0, 8'h01, lcdseq_pkg::WAIT_LONG, 1'b1});
        dir_rows[9]  = dir_row(1'b0, lcdseq_pkg::OP_INIT,    8'h00, 7'h00, 2'd0, 3'b000,
                               1'b0, NO_STROBE);
        dir_rows[10] = dir_row(1'b0, OP_RSVD6,               8'h00, 7'h00, 2'd0, 3'b000,
                               1'b0, NO_STROBE);
        dir_rows[11] = dir_row(1'b0, OP_RSVD7,               8'hFF, 7'h7F, 2'd3, 3'b111,
                               1'b0, NO_STROBE);
        dir_rows[12] = dir_row(1'b1, lcdseq_pkg::OP_CMD,     8'hA5, 7'h00, 2'd0, 3'b000,
                               1'b0, NO_STROBE);
        dir_rows[13] = dir_row(1'b1, lcdseq_pkg::OP_DATA,    8'hFF, 7'h7F, 2'd3, 3'b111,
                               1'b0, NO_STROBE);
        dir_rows[14] = dir_row(1'b1, lcdseq_pkg::OP_DATA,    8'h00, 7'h00, 2'd0, 3'b000,
                               1'b0, NO_STROBE);
        dir_rows[15] = dir_row(1'b1, lcdseq_pkg::OP_CURSOR,  8'h00, 7'h3F, 2'd1, 3'b000,
                               1'b0, NO_STROBE);
        dir_rows[16] = dir_row(1'b1, lcdseq_pkg::OP_CURSOR,  8'hFF, 7'h7F, 2'd2, 3'b111,
                               1'b0, NO_STROBE);
        dir_rows[17] = dir_row(1'b1, lcdseq_pkg::OP_DISPLAY, 8'h00, 7'h00, 2'd0, 3'b101,
                               1'b0, NO_STROBE);
        dir_rows[18] = dir_row(1'b1, lcdseq_pkg::OP_CLEAR,   8'h00, 7'h00, 2'd0, 3'b000,
                               1'b0, NO_STROBE);
        dir_rows[19] = dir_row(1'b1, lcdseq_pkg::OP_INIT,    8'hFF, 7'h7F, 2'd3, 3'b111,
                               1'b0, NO_STROBE);
        dir_rows[20] = dir_row(1'b1, OP_RSVD7,               8'hFF, 7'h7F, 2'd3, 3'b111,
                               1'b0, NO_STROBE);
        dir_rows[21] = dir_row(1'b0, lcdseq_pkg::OP_INIT,    8'h00, 7'h00, 2'd0, 3'b000,
                               1'b0, NO_STROBE);
        dir_rows[22] = dir_row(1'b0, lcdseq_pkg::OP_CURSOR,  8'h00, 7'h7F, 2'd1, 3'b000,
                               1'b0, NO_STROBE);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_bus(1'b0);

        // Directed table; a bus width change waits for the block to go idle
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].bus_nib != bus_nib) set_bus(dir_rows[i].bus_nib);
            send_req(dir_rows[i].req, dir_rows[i].has_fixed, dir_rows[i].fixed);
        end

        // Random requests in segments, toggling bus width between segments
        seg_left = $urandom_range(15, 45);
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (seg_left == 0) begin
                set_bus(!bus_nib);
                seg_left = $urandom_range(15, 45);
            end else if (i == RAND_ITEMS / 2) begin
                settle();
            end
            seg_left--;
            r = lcdseq_pkg::t_req'(REQ_W'($urandom));
            if ($urandom_range(0, 9) == 0) r.opcode = 3'($urandom_range(6, 7));
            else r.opcode = 3'($urandom_range(0, 5));
            send_req(r, 1'b0, NO_STROBE);
        end

        settle();
        if (errors == 0 && pending_strobes.size() == 0) begin
            $display("char_lcd_bus_sequencer_top test passed");
        end else begin
            $display("char_lcd_bus_sequencer_top test failed");
        end
        $finish;
    end

    // Result side: random stalls, then take and check one strobe transaction
    initial begin : strobe_sink
        lcdseq_pkg::t_strobe got;
        lcdseq_pkg::t_strobe want;
        int                  stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = take_eager ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got = o_strobe;
            if (pending_strobes.size() == 0) begin
                $display("%0t: unexpected strobe rs=%0d bus=%02h wait=%0d last=%0d", $time,
                         got.register_select, got.bus_value, got.wait_after_ms,
                         got.last_strobe);
                errors++;
            end else begin
                want = pending_strobes.pop_front();
                if (got.register_select !== want.register_select ||
                    got.bus_value !== want.bus_value ||
                    got.wait_after_ms !== want.wait_after_ms ||
                    got.last_strobe !== want.last_strobe) begin
                    $display("%0t: strobe mismatch: expected rs=%0d bus=%02h wait=%0d last=%0d",
                             $time, want.register_select, want.bus_value,
                             want.wait_after_ms, want.last_strobe);
                    $display("%0t:                  actual   rs=%0d bus=%02h wait=%0d last=%0d",
                             $time, got.register_select, got.bus_value,
                             got.wait_after_ms, got.last_strobe);
                    errors++;
                end
            end
            if ($urandom_range(0, 15) == 0) take_eager = !take_eager;
        end
    end

    // Watchdog
    initial begin : watchdog
        #3000000;
        $display("char_lcd_bus_sequencer_top test failed");
        $finish;
    end

endmodule
